// ===== hw/rtl/baro_pressure_temp_compensation_macros.svh =====
// Assertion macros shared by the barometric compensation block.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// Implication checked at every rising edge of clk, suspended while rst_n is low.
`define BARO_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked at every rising edge of clk, suspended while rst_n is low.
`define BARO_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/baro_pkg.sv =====
// Types and constants shared by the barometric compensation pipeline.
`timescale 1ns / 1ps

package baro_pkg;

    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int DT_W    = RAW_W + 1;
    localparam int PROD_W  = 42;
    localparam int SQ_W    = 2 * DT_W;
    localparam int TEMP_W  = 20;
    localparam int WIDE_W  = 42;
    localparam int LO_W    = 21;
    localparam int PLO_W   = RAW_W + LO_W;
    localparam int PHI_W   = RAW_W + 1 + WIDE_W - LO_W;
    localparam int Q_W     = 48;
    localparam int PRES_W  = 32;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam int SEG_STAGES = 3;
    localparam int PIPE_DEPTH = 3 * SEG_STAGES;
    localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW = -20'sd1500;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_COEFF        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COEFF      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP_RAW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE_COEFF  = 3'd5;

    typedef struct packed {
        logic [COEFF_W-1:0] sens_coeff;
        logic [COEFF_W-1:0] offset_coeff;
        logic [COEFF_W-1:0] sens_temp_coeff;
        logic [COEFF_W-1:0] offset_temp_coeff;
        logic [COEFF_W-1:0] ref_temp_raw;
        logic [COEFF_W-1:0] temp_slope_coeff;
    } coeff_t;

    typedef struct packed {
        logic [RAW_W-1:0] temperature_raw;
        logic [RAW_W-1:0] pressure_raw;
    } sample_t;

    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic signed [TEMP_W-1:0] temp1;
        logic signed [TEMP_W-1:0] t2;
        logic signed [WIDE_W-1:0] off1;
        logic signed [WIDE_W-1:0] sens1;
    } first_t;

    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
    } corr_t;

    typedef struct packed {
        logic signed [PRES_W-1:0] pres_pa;
        logic signed [TEMP_W-1:0] temp_centi;
    } result_t;

endpackage

// ===== hw/rtl/baro_first.sv =====
// First-order stages: temperature difference, coefficient products, first-order terms.
`timescale 1ns / 1ps

module baro_first (
    input  logic            clk,
    input  logic            rst_n,
    input  baro_pkg::coeff_t  coeff,
    input  logic            in_valid,
    output logic            in_ready,
    input  baro_pkg::sample_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output baro_pkg::first_t  out_data
);
    import baro_pkg::*;

    logic [SEG_STAGES-1:0] valid_reg;
    logic [SEG_STAGES-1:0] en;

    logic signed [DT_W-1:0]   dt_reg;
    logic signed [DT_W-1:0]   dt_next;
    logic        [RAW_W-1:0]  d1_s1_reg;

    logic signed [PROD_W-1:0] prod_temp_reg;
    logic signed [PROD_W-1:0] prod_off_reg;
    logic signed [PROD_W-1:0] prod_sens_reg;
    logic signed [SQ_W-1:0]   prod_dd_reg;
    logic signed [PROD_W-1:0] prod_temp_next;
    logic signed [PROD_W-1:0] prod_off_next;
    logic signed [PROD_W-1:0] prod_sens_next;
    logic signed [SQ_W-1:0]   prod_dd_next;
    logic        [RAW_W-1:0]  d1_s2_reg;

    first_t out_reg;
    first_t out_next;

    assign en[2]    = !valid_reg[2] || out_ready;
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    assign dt_next = $signed({1'b0, in_data.temperature_raw})
                   - $signed({1'b0, coeff.ref_temp_raw, 8'h00});

    assign prod_temp_next = PROD_W'(dt_reg)
                          * PROD_W'($signed({1'b0, coeff.temp_slope_coeff}));
    assign prod_off_next  = PROD_W'(dt_reg)
                          * PROD_W'($signed({1'b0, coeff.offset_temp_coeff}));
    assign prod_sens_next = PROD_W'(dt_reg)
                          * PROD_W'($signed({1'b0, coeff.sens_temp_coeff}));
    assign prod_dd_next   = SQ_W'(dt_reg) * SQ_W'(dt_reg);

    always_comb
    begin
        out_next.d1    = d1_s2_reg;
        out_next.temp1 = TEMP_W'(prod_temp_reg >>> 23) + TEMP_REF;
        out_next.t2    = TEMP_W'(prod_dd_reg >>> 31);
        out_next.off1  = $signed({10'b0, coeff.offset_coeff, 16'h0000})
                       + WIDE_W'(prod_off_reg >>> 7);
        out_next.sens1 = $signed({11'b0, coeff.sens_coeff, 15'h0000})
                       + WIDE_W'(prod_sens_reg >>> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt_reg    <= dt_next;
            d1_s1_reg <= in_data.pressure_raw;
        end
        if (en[1])
        begin
            prod_temp_reg <= prod_temp_next;
            prod_off_reg  <= prod_off_next;
            prod_sens_reg <= prod_sens_next;
            prod_dd_reg   <= prod_dd_next;
            d1_s2_reg     <= d1_s1_reg;
        end
        if (en[2])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/baro_corr.sv =====
// Second-order correction stages for temperatures below 20.00 and -15.00 degrees.
`timescale 1ns / 1ps

module baro_corr (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  baro_pkg::first_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output baro_pkg::corr_t   out_data
);
    import baro_pkg::*;

    logic [SEG_STAGES-1:0] valid_reg;
    logic [SEG_STAGES-1:0] en;

    logic signed [TEMP_W-1:0] a_dist;
    logic signed [TEMP_W-1:0] b_dist;
    logic signed [WIDE_W-1:0] aa_reg;
    logic signed [WIDE_W-1:0] bb_reg;
    logic signed [WIDE_W-1:0] aa_next;
    logic signed [WIDE_W-1:0] bb_next;
    logic                     lt_ref_reg;
    logic                     lt_low_reg;
    first_t                   s4_reg;

    logic signed [WIDE_W-1:0] off2_base;
    logic signed [WIDE_W-1:0] sens2_base;
    logic signed [WIDE_W-1:0] off2_extra;
    logic signed [WIDE_W-1:0] sens2_extra;
    logic signed [WIDE_W-1:0] off2_reg;
    logic signed [WIDE_W-1:0] sens2_reg;
    logic signed [TEMP_W-1:0] t2g_reg;
    logic signed [WIDE_W-1:0] off2_next;
    logic signed [WIDE_W-1:0] sens2_next;
    logic signed [TEMP_W-1:0] t2g_next;
    first_t                   s5_reg;

    corr_t out_reg;
    corr_t out_next;

    assign en[2]    = !valid_reg[2] || out_ready;
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    assign a_dist  = in_data.temp1 - TEMP_REF;
    assign b_dist  = in_data.temp1 - TEMP_LOW;
    assign aa_next = WIDE_W'(a_dist) * WIDE_W'(a_dist);
    assign bb_next = WIDE_W'(b_dist) * WIDE_W'(b_dist);

    // Five halves and five quarters of a squared, then seven times and eleven halves of b squared below -15.00.
    assign off2_base   = ((aa_reg <<< 2) + aa_reg) >>> 1;
    assign sens2_base  = off2_base >>> 1;
    assign off2_extra  = (bb_reg <<< 3) - bb_reg;
    assign sens2_extra = ((bb_reg <<< 3) + (bb_reg <<< 1) + bb_reg) >>> 1;

    always_comb
    begin
        off2_next  = '0;
        sens2_next = '0;
        t2g_next   = '0;
        if (lt_ref_reg)
        begin
            t2g_next = s4_reg.t2;
            if (lt_low_reg)
            begin
                off2_next  = off2_base + off2_extra;
                sens2_next = sens2_base + sens2_extra;
            end
            else
            begin
                off2_next  = off2_base;
                sens2_next = sens2_base;
            end
        end
    end

    always_comb
    begin
        out_next.d1   = s5_reg.d1;
        out_next.temp = s5_reg.temp1 - t2g_reg;
        out_next.off  = s5_reg.off1 - off2_reg;
        out_next.sens = s5_reg.sens1 - sens2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            aa_reg     <= aa_next;
            bb_reg     <= bb_next;
            lt_ref_reg <= in_data.temp1 < TEMP_REF;
            lt_low_reg <= in_data.temp1 < TEMP_LOW;
            s4_reg     <= in_data;
        end
        if (en[1])
        begin
            off2_reg  <= off2_next;
            sens2_reg <= sens2_next;
            t2g_reg   <= t2g_next;
            s5_reg    <= s4_reg;
        end
        if (en[2])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/baro_pres.sv =====
// Pressure stages: split raw pressure product, scaling and the result register.
`timescale 1ns / 1ps

module baro_pres (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  baro_pkg::corr_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output baro_pkg::result_t out_data
);
    import baro_pkg::*;

    logic [SEG_STAGES-1:0] valid_reg;
    logic [SEG_STAGES-1:0] en;

    logic        [PLO_W-1:0]  p_lo_reg;
    logic signed [PHI_W-1:0]  p_hi_reg;
    logic        [PLO_W-1:0]  p_lo_next;
    logic signed [PHI_W-1:0]  p_hi_next;
    logic signed [TEMP_W-1:0] temp_s7_reg;
    logic signed [WIDE_W-1:0] off_s7_reg;

    logic signed [Q_W-1:0]    q_reg;
    logic signed [Q_W-1:0]    q_next;
    logic signed [TEMP_W-1:0] temp_s8_reg;

    result_t out_reg;
    result_t out_next;

    assign en[2]    = !valid_reg[2] || out_ready;
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    // The product is taken in two halves of the sensitivity; the high half
    // already sits at the 21-bit scaling position.
    assign p_lo_next = PLO_W'(in_data.d1) * PLO_W'(in_data.sens[LO_W-1:0]);
    assign p_hi_next = PHI_W'($signed({1'b0, in_data.d1}))
                     * PHI_W'($signed(in_data.sens[WIDE_W-1:LO_W]));

    assign q_next = Q_W'(p_hi_reg)
                  + Q_W'($signed({1'b0, p_lo_reg[PLO_W-1:LO_W]}))
                  - Q_W'(off_s7_reg);

    always_comb
    begin
        out_next.temp_centi = temp_s8_reg;
        out_next.pres_pa    = PRES_W'(q_reg >>> 15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_lo_reg    <= p_lo_next;
            p_hi_reg    <= p_hi_next;
            temp_s7_reg <= in_data.temp;
            off_s7_reg  <= in_data.off;
        end
        if (en[1])
        begin
            q_reg       <= q_next;
            temp_s8_reg <= temp_s7_reg;
        end
        if (en[2])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/baro_pressure_temp_compensation.sv =====
// Top level of the barometric pressure and temperature compensation pipeline.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  s_tdata: pressure_raw, temperature_raw
//   m_*      out        m_tvalid/m_tready  m_tdata: temp_centi, pres_pa
//   cfg_*    in         cfg_wr_en          cfg_index, cfg_wdata (six coefficients)
//
// An accepted request passes through nine stages, three per segment, to the output
// register; one request enters per cycle while the pipeline is not stalled.
// Reset clears the stage valid bits and sets all six coefficients to zero.
// A stall holds each full stage while empty stages upstream keep filling.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_macros.svh"

module baro_pressure_temp_compensation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] pressure_raw, [47:24] temperature_raw
    input  logic [baro_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [19:0] temp_centi, [51:20] pres_pa, [55:52] zero
    output logic [baro_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [baro_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [baro_pkg::COEFF_W-1:0]        cfg_wdata
);
    import baro_pkg::*;

    coeff_t  coeff_reg;
    coeff_t  coeff_next;
    sample_t sample;

    logic    first_valid;
    logic    first_ready;
    first_t  first_data;
    logic    corr_valid;
    logic    corr_ready;
    corr_t   corr_data;
    result_t result;

    logic             in_acc;
    logic             out_acc;
    logic [OCC_W-1:0] occupancy_reg;
    logic [OCC_W-1:0] occupancy_next;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SENS_COEFF:        coeff_next.sens_coeff        = cfg_wdata;
                REG_OFFSET_COEFF:      coeff_next.offset_coeff      = cfg_wdata;
                REG_SENS_TEMP_COEFF:   coeff_next.sens_temp_coeff   = cfg_wdata;
                REG_OFFSET_TEMP_COEFF: coeff_next.offset_temp_coeff = cfg_wdata;
                REG_REF_TEMP_RAW:      coeff_next.ref_temp_raw      = cfg_wdata;
                REG_TEMP_SLOPE_COEFF:  coeff_next.temp_slope_coeff  = cfg_wdata;
                default:               coeff_next                   = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    assign sample.pressure_raw    = s_tdata[RAW_W-1:0];
    assign sample.temperature_raw = s_tdata[2*RAW_W-1:RAW_W];

    baro_first u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .coeff     (coeff_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (sample),
        .out_valid (first_valid),
        .out_ready (first_ready),
        .out_data  (first_data)
    );

    baro_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (first_valid),
        .in_ready  (first_ready),
        .in_data   (first_data),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_data  (corr_data)
    );

    baro_pres u_pres (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (corr_valid),
        .in_ready  (corr_ready),
        .in_data   (corr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {(OUT_DATA_W - PRES_W - TEMP_W)'(0), result.pres_pa, result.temp_centi};

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign occupancy_next = occupancy_reg + OCC_W'(in_acc) - OCC_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
        end
        else
        begin
            occupancy_reg <= occupancy_next;
        end
    end

    `BARO_ASSERT_IMPL(a_ready_when_drained, m_tready, s_tready, "input stalled while output drains")
    `BARO_ASSERT_ALWAYS(a_occupancy_bound, occupancy_reg <= OCC_W'(PIPE_DEPTH), "pipeline overfull")
    `BARO_ASSERT_IMPL(a_no_phantom_result, occupancy_reg == '0, !m_tvalid, "result while empty")

endmodule

// ===== sim/baro_pressure_temp_compensation_test.sv =====
// Self-checking testbench for the barometric pressure and temperature compensation block.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_test;
    import baro_pkg::*;

    localparam longint TEMP_KNEE      = 2000;
    localparam longint COLD_KNEE      = -1500;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int     ROUND_ITEMS    = 205;
    localparam int     RANDOM_ROUNDS  = 9;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     IDLE_PCT       = 38;
    localparam int     SETTLE_CYCLES  = PIPE_DEPTH + 4;
    localparam int     CYCLE_LIMIT    = 200000;
    localparam int     REPORT_LIMIT   = 10;
    localparam int     PAD_W          = OUT_DATA_W - TEMP_W - PRES_W;

    class compensation_tracker;
        coeff_t  coeffs;
        result_t pending_readings[$];
        int      failures;

        function new();
            coeffs   = '0;
            failures = 0;
        endfunction

        function void set_coeff(logic [CFG_IDX_W-1:0] index, logic [COEFF_W-1:0] value);
            case (index)
                REG_SENS_COEFF:        coeffs.sens_coeff        = value;
                REG_OFFSET_COEFF:      coeffs.offset_coeff      = value;
                REG_SENS_TEMP_COEFF:   coeffs.sens_temp_coeff   = value;
                REG_OFFSET_TEMP_COEFF: coeffs.offset_temp_coeff = value;
                REG_REF_TEMP_RAW:      coeffs.ref_temp_raw      = value;
                REG_TEMP_SLOPE_COEFF:  coeffs.temp_slope_coeff  = value;
                default: ;
            endcase
        endfunction

        function result_t compensate(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
            longint  d1;
            longint  dt;
            longint  temp;
            longint  off;
            longint  sens;
            longint  t2;
            longint  delta;
            longint  off2;
            longint  sens2;
            longint  cold;
            longint  cold_sq;
            longint  p;
            result_t r;
            d1   = longint'(d1_raw);
            dt   = longint'(d2_raw) - longint'(coeffs.ref_temp_raw) * 256;
            temp = TEMP_KNEE + ((dt * longint'(coeffs.temp_slope_coeff)) >>> 23);
            off  = longint'(coeffs.offset_coeff) * 65536
                   + ((longint'(coeffs.offset_temp_coeff) * dt) >>> 7);
            sens = longint'(coeffs.sens_coeff) * 32768
                   + ((longint'(coeffs.sens_temp_coeff) * dt) >>> 8);
            if (temp < TEMP_KNEE)
            begin
                t2    = (dt * dt) >>> 31;
                delta = temp - TEMP_KNEE;
                off2  = (5 * delta * delta) >>> 1;
                sens2 = off2 >>> 1;
                if (temp < COLD_KNEE)
                begin
                    cold    = temp - COLD_KNEE;
                    cold_sq = cold * cold;
                    off2    = off2 + 7 * cold_sq;
                    sens2   = sens2 + ((11 * cold_sq) >>> 1);
                end
                temp = temp - t2;
                off  = off - off2;
                sens = sens - sens2;
            end
            p = (((d1 * sens) >>> 21) - off) >>> 15;
            r.temp_centi = temp[TEMP_W-1:0];
            r.pres_pa    = p[PRES_W-1:0];
            return r;
        endfunction

        function void note_sample(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
            pending_readings.push_back(compensate(d1_raw, d2_raw));
        endfunction

        function void check_reading(logic [TEMP_W-1:0] temp, logic [PRES_W-1:0] pres,
                                    logic [PAD_W-1:0] pad);
            result_t want;
            if (pending_readings.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Unexpected reading: temp=%0d pressure=%0d",
                             $signed(temp), $signed(pres));
                return;
            end
            want = pending_readings.pop_front();
            if (temp !== want.temp_centi || pres !== want.pres_pa || pad !== '0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Mismatch: want temp=%0d pres=%0d, got temp=%0d pres=%0d pad=%h",
                             want.temp_centi, want.pres_pa,
                             $signed(temp), $signed(pres), pad);
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COEFF_W-1:0]    cfg_wdata = '0;

    bit src_gaps       = 1'b1;
    bit sink_gaps      = 1'b1;
    int stall_requests = 0;
    int stall_served   = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    compensation_tracker tracker;

    baro_pressure_temp_compensation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.note_sample(s_tdata[RAW_W-1:0], s_tdata[2*RAW_W-1:RAW_W]);
            if (m_tvalid && m_tready)
                tracker.check_reading(m_tdata[TEMP_W-1:0], m_tdata[TEMP_W+PRES_W-1:TEMP_W],
                                      m_tdata[OUT_DATA_W-1:TEMP_W+PRES_W]);
        end
    end

    // The receiver either holds off for a long stretch on request or idles at random.
    always @(negedge clk)
    begin
        if (stall_served != stall_requests)
        begin
            stall_served = stall_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(sink_gaps && $urandom_range(99) < IDLE_PCT);
    end

    task automatic push_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        while (src_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d2, d1};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [COEFF_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        tracker.set_coeff(index, value);
        @(negedge clk);
    endtask

    task automatic program_coeffs(input coeff_t c);
        write_reg(REG_SENS_COEFF, c.sens_coeff);
        write_reg(REG_OFFSET_COEFF, c.offset_coeff);
        write_reg(REG_SENS_TEMP_COEFF, c.sens_temp_coeff);
        write_reg(REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
        write_reg(REG_REF_TEMP_RAW, c.ref_temp_raw);
        write_reg(REG_TEMP_SLOPE_COEFF, c.temp_slope_coeff);
        // Writes to unused indexes come last so that any aliasing corrupts a live coefficient.
        write_reg(REG_SPARE_LO, COEFF_W'($urandom));
        write_reg(REG_SPARE_HI, COEFF_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [COEFF_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        sample_t          s;
        logic [RAW_W-1:0] ref_raw;
        ref_raw          = {tracker.coeffs.ref_temp_raw, 8'd0};
        s.pressure_raw   = RAW_W'($urandom);
        case ($urandom_range(9))
            0:       s.pressure_raw = '0;
            1:       s.pressure_raw = '1;
            default: ;
        endcase
        case ($urandom_range(9))
            0, 1:    s.temperature_raw = ref_raw + RAW_W'(int'($urandom_range(65535)) - 32768);
            2:       s.temperature_raw = ref_raw
                                         + RAW_W'(int'($urandom_range(4194303)) - 2097152);
            3:       s.temperature_raw = $urandom_range(1) ? '1 : '0;
            default: s.temperature_raw = RAW_W'($urandom);
        endcase
        return s;
    endfunction

    initial
    begin
        coeff_t  c;
        sample_t s;
        tracker = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_sample(24'h000000, 24'h000000);
        push_sample(24'hFFFFFF, 24'hFFFFFF);
        push_sample(24'h123456, 24'h654321);
        drain_results();

        c.sens_coeff        = 16'd40127;
        c.offset_coeff      = 16'd36924;
        c.sens_temp_coeff   = 16'd23317;
        c.offset_temp_coeff = 16'd23282;
        c.ref_temp_raw      = 16'd33464;
        c.temp_slope_coeff  = 16'd28312;
        program_coeffs(c);
        push_sample(24'd9085466, 24'd8569150);
        push_sample(24'd0, 24'd8566784);
        push_sample(24'hFFFFFF, 24'd8566784);
        // Just below twenty degrees, and around the cold threshold before correction.
        push_sample(24'd9085466, 24'd8566783);
        push_sample(24'd9085466, 24'd7529764);
        push_sample(24'd9085466, 24'd7529763);
        push_sample(24'h000000, 24'h000000);
        push_sample(24'hFFFFFF, 24'h000000);
        push_sample(24'h000000, 24'hFFFFFF);
        push_sample(24'hFFFFFF, 24'hFFFFFF);
        push_sample(24'h555555, 24'hAAAAAA);
        push_sample(24'hAAAAAA, 24'h555555);
        drain_results();

        c = '1;
        program_coeffs(c);
        push_sample(24'h000000, 24'h000000);
        push_sample(24'hFFFFFF, 24'h000000);
        push_sample(24'h000000, 24'hFFFFFF);
        push_sample(24'hFFFFFF, 24'hFFFFFF);
        push_sample(24'h555555, 24'hAAAAAA);

        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            drain_results();
            if (round == 0)
                c = '0;
            else
            begin
                c.sens_coeff        = pick_word();
                c.offset_coeff      = pick_word();
                c.sens_temp_coeff   = pick_word();
                c.offset_temp_coeff = pick_word();
                c.ref_temp_raw      = pick_word();
                c.temp_slope_coeff  = pick_word();
            end
            program_coeffs(c);
            src_gaps  = (round != 3);
            sink_gaps = (round != 3);
            if (round == 5)
            begin
                src_gaps       = 1'b0;
                stall_requests = stall_requests + 1;
            end
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                if (round == 6 && n == ROUND_ITEMS / 2)
                    drain_results();
                s = pick_sample();
                push_sample(s.pressure_raw, s.temperature_raw);
            end
        end
        drain_results();

        if (tracker.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
